/* design/uskp_pkg.sv */
package uskp_pkg;

    // key layout
    localparam int KEY_SLOTS  = 3;
    localparam int SLOT_BITS  = 21;
    localparam int KEY_W      = 63;
    localparam int COUNT_W    = 3;
    localparam int PEND_W     = 2;

    // count saturates here, meaning more points than slots
    localparam logic [COUNT_W-1:0] COUNT_SAT   = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_SLOTS = COUNT_W'(KEY_SLOTS);

    // continuation bytes still expected after each lead form
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd2;
    localparam logic [PEND_W-1:0] PEND_FOUR  = 2'd3;

    typedef logic [SLOT_BITS-1:0] t_code;
    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [PEND_W-1:0]    t_pend;

endpackage

/* design/uskp_byte_if.sv */
interface uskp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

/* design/uskp_key_if.sv */
interface uskp_key_if
    import uskp_pkg::*;
;
    logic   valid;
    logic   ready;
    t_key   packed_key;
    t_count point_count;

    modport source (output valid, output packed_key, output point_count, input ready);
    modport sink   (input valid, input packed_key, input point_count, output ready);
endinterface

/* design/utf8_short_string_key_packer_top.sv */
// utf8 short string key packer
//
// i_in carries one byte of a utf-8 string per request, with last_byte set on
// the final byte. o_out carries one request per string: the code points
// packed in 21-bit slots, first point highest (zero unless one to three
// points were decoded), and the point count, saturating at four.
//
// a byte is taken into the input register and decoded from there; on a last
// byte the result is written into the output register, from which the key is
// offered. the block takes one byte per cycle while no last byte waits on a
// full output register; the decode state update is one short shift-and-or
// step per byte.
//
// reset (synchronous, active low) empties both registers and clears the
// decode state. when the receiver stalls with a key waiting, bytes that
// produce no key still pass through the decoder; a further last byte holds
// in the input register and i_in.ready drops once that register is full.
module utf8_short_string_key_packer_top
    import uskp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    uskp_byte_if.sink   i_in,
    uskp_key_if.source  o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // decode state
    t_code  r_code,  n_code;
    t_pend  r_pend,  n_pend;
    t_count r_pts,   n_pts;
    t_key   r_key,   n_key;
    logic   r_halt,  n_halt;

    // output register
    logic   r_out_valid;
    t_key   r_out_key;
    t_count r_out_cnt;

    logic   out_free;
    logic   advance;
    logic   finish;
    t_code  step_code;
    t_key   res_key;

    // a last byte needs the output register, other bytes move freely
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (!r_last || out_free);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.byte_in;
            r_last <= i_in.last_byte;
        end
    end

    // byte decode and point completion
    always_comb begin
        n_code    = r_code;
        n_pend    = r_pend;
        n_pts     = r_pts;
        n_key     = r_key;
        n_halt    = r_halt;
        finish    = 1'b0;
        step_code = r_code;
        if (!r_halt) begin
            if (r_pend != PEND_NONE) begin
                step_code = {r_code[SLOT_BITS-7:0], r_byte[5:0]};
                n_pend    = r_pend - PEND_TWO;
                finish    = (r_pend == PEND_TWO);
            end else begin
                case (r_byte) inside
                    8'b0???????: begin
                        step_code = {{(SLOT_BITS-7){1'b0}}, r_byte[6:0]};
                        finish    = 1'b1;
                    end
                    8'b110?????: begin
                        step_code = {{(SLOT_BITS-5){1'b0}}, r_byte[4:0]};
                        n_pend    = PEND_TWO;
                    end
                    8'b1110????: begin
                        step_code = {{(SLOT_BITS-4){1'b0}}, r_byte[3:0]};
                        n_pend    = PEND_THREE;
                    end
                    8'b11110???: begin
                        step_code = {{(SLOT_BITS-3){1'b0}}, r_byte[2:0]};
                        n_pend    = PEND_FOUR;
                    end
                    default: begin
                        step_code = '0;
                        n_halt    = 1'b1;
                    end
                endcase
            end
            n_code = step_code;
            // a zero point stops decoding, others shift into the key until the count saturates
            if (finish) begin
                if (step_code == '0) begin
                    n_halt = 1'b1;
                end else begin
                    if (r_pts < COUNT_SAT) begin
                        n_key = {r_key[KEY_W-SLOT_BITS-1:0], step_code};
                        n_pts = r_pts + t_count'(1);
                    end
                    n_code = '0;
                end
            end
        end
    end

    // key is kept only for one to KEY_SLOTS points
    assign res_key = (n_pts != '0 && n_pts <= COUNT_SLOTS) ? n_key : '0;

    // decode state, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_pend <= PEND_NONE;
            r_pts  <= '0;
            r_key  <= '0;
            r_halt <= 1'b0;
        end else if (advance) begin
            if (r_last) begin
                r_code <= '0;
                r_pend <= PEND_NONE;
                r_pts  <= '0;
                r_key  <= '0;
                r_halt <= 1'b0;
            end else begin
                r_code <= n_code;
                r_pend <= n_pend;
                r_pts  <= n_pts;
                r_key  <= n_key;
                r_halt <= n_halt;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_last;
        end
        if (out_free && advance && r_last) begin
            r_out_key <= res_key;
            r_out_cnt <= n_pts;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.packed_key  = r_out_key;
    assign o_out.point_count = r_out_cnt;

endmodule
